FILE: src/lpfd_pkg.sv
package lpfd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [BYTE_W-1:0] MARKER_BYTE  = 8'h01;
  localparam logic [LEN_W-1:0]  HEADER_BYTES = 32'd6;

  // header_pos values with a meaning of their own
  localparam logic [POS_W-1:0] POS_MARKER = 3'd0;
  localparam logic [POS_W-1:0] POS_TYPE   = 3'd1;
  localparam logic [POS_W-1:0] POS_LAST   = 3'd5;

  localparam logic [LEN_W-1:0]  RST_MAX_FRAME = 32'd65542;
  localparam logic [BYTE_W-1:0] RST_TYPE_A    = 8'd0;
  localparam logic [BYTE_W-1:0] RST_TYPE_B    = 8'd2;
  localparam logic [BYTE_W-1:0] RST_SEALED    = 8'd1;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    WHY_NONE   = 2'd0,
    WHY_MARKER = 2'd1,
    WHY_TYPE   = 2'd2,
    WHY_SIZE   = 2'd3
  } why_t;

  typedef enum logic [1:0] {
    REG_MAX_FRAME = 2'd0,
    REG_TYPE_A    = 2'd1,
    REG_TYPE_B    = 2'd2,
    REG_SEALED    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0]  max_frame_size;
    logic [BYTE_W-1:0] plain_type_a;
    logic [BYTE_W-1:0] plain_type_b;
    logic [BYTE_W-1:0] sealed_type;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] ftype;
    logic              fend;
    why_t              why;
  } result_t;

endpackage

FILE: src/lpfd_ifs.sv
interface lpfd_byte_if;
  logic                           valid;
  logic                           ready;
  logic [lpfd_pkg::BYTE_W-1:0]    in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpfd_result_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     out_kind;
  logic [lpfd_pkg::BYTE_W-1:0]    out_byte;
  logic [lpfd_pkg::BYTE_W-1:0]    frame_kind;
  logic                           frame_end;
  logic [1:0]                     reject_reason;

  modport source (output valid, output out_kind, output out_byte, output frame_kind,
                  output frame_end, output reject_reason, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input frame_kind,
                  input frame_end, input reject_reason, output ready);
endinterface

FILE: src/length_prefixed_frame_deframer.sv
// Path: an accepted byte passes the input register, then the result register;
//   header bytes give no result, but a rejected marker byte and the last header byte can.
// Throughput: one byte per cycle; the result register is the only point that stalls.
// Reset (rst, synchronous): clears both registers' valid flags and the frame state,
//   and loads the register defaults; no clearing pass.
module length_prefixed_frame_deframer (
  input  logic                              clk,
  input  logic                              rst,
  lpfd_byte_if.sink                         stream,
  lpfd_result_if.source                     result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpfd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lpfd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lpfd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lpfd_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    res_take;

  lpfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (stream.valid),
    .in_byte   (stream.in_byte),
    .in_ready  (stream.ready),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res       (res)
  );

  lpfd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .take      (res_take),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_res   (out_res)
  );

  assign result.out_kind      = out_res.kind;
  assign result.out_byte      = out_res.data;
  assign result.frame_kind    = out_res.ftype;
  assign result.frame_end     = out_res.fend;
  assign result.reject_reason = out_res.why;

  // input side stalls only behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !stream.ready |-> result.valid)
    else $error("input stalled with no result pending");

  a_reason_only_on_reject: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.out_kind != KIND_REJECT) |-> result.reject_reason == WHY_NONE)
    else $error("reason code on a non-reject transaction");

  a_reject_not_end: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.out_kind == KIND_REJECT) |-> !result.frame_end && result.out_byte == '0)
    else $error("reject transaction carries frame end or data");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

endmodule

FILE: src/lpfd_cfg_regs.sv
module lpfd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpfd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lpfd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lpfd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output lpfd_pkg::cfg_t                    cfg
);
  import lpfd_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_frame_size <= RST_MAX_FRAME;
      cfg.plain_type_a   <= RST_TYPE_A;
      cfg.plain_type_b   <= RST_TYPE_B;
      cfg.sealed_type    <= RST_SEALED;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_FRAME: cfg.max_frame_size <= pwdata[LEN_W-1:0];
        REG_TYPE_A:    cfg.plain_type_a   <= pwdata[BYTE_W-1:0];
        REG_TYPE_B:    cfg.plain_type_b   <= pwdata[BYTE_W-1:0];
        REG_SEALED:    cfg.sealed_type    <= pwdata[BYTE_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_FRAME: prdata = APB_DATA_W'(cfg.max_frame_size);
      REG_TYPE_A:    prdata = APB_DATA_W'(cfg.plain_type_a);
      REG_TYPE_B:    prdata = APB_DATA_W'(cfg.plain_type_b);
      REG_SEALED:    prdata = APB_DATA_W'(cfg.sealed_type);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: src/lpfd_parser.sv
module lpfd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  lpfd_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  input  logic [lpfd_pkg::BYTE_W-1:0]   in_byte,
  output logic                          in_ready,
  input  logic                          res_take,
  output logic                          res_valid,
  output lpfd_pkg::result_t             res
);
  import lpfd_pkg::*;

  // input register
  logic              in_full;
  logic [BYTE_W-1:0] byte_r;

  // frame state
  logic [POS_W-1:0]  header_pos, header_pos_next;
  logic              in_payload, in_payload_next;
  logic [BYTE_W-1:0] held_type, held_type_next;
  logic [LEN_W-1:0]  length_acc, length_acc_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;

  logic              has_res;
  logic              advance;
  logic [LEN_W-1:0]  acc_shift;
  logic [LEN_W-1:0]  limit;
  logic              max_small;
  logic              type_ok;

  assign acc_shift = {length_acc[LEN_W-BYTE_W-1:0], byte_r};
  assign max_small = cfg.max_frame_size < HEADER_BYTES;
  assign limit     = cfg.max_frame_size - HEADER_BYTES;
  assign type_ok   = (held_type == cfg.plain_type_a) || (held_type == cfg.plain_type_b) ||
                     (held_type == cfg.sealed_type);

  always_comb begin
    header_pos_next = header_pos;
    in_payload_next = in_payload;
    held_type_next  = held_type;
    length_acc_next = length_acc;
    bytes_left_next = bytes_left;
    has_res         = 1'b0;
    res             = '{kind: KIND_DATA, data: '0, ftype: '0, fend: 1'b0, why: WHY_NONE};

    priority if (in_payload) begin
      has_res   = 1'b1;
      res.data  = byte_r;
      res.ftype = held_type;
      res.fend  = bytes_left <= LEN_W'(1);
      if (res.fend) begin
        bytes_left_next = '0;
        in_payload_next = 1'b0;
        header_pos_next = POS_MARKER;
      end else begin
        bytes_left_next = bytes_left - LEN_W'(1);
      end
    end else if (header_pos == POS_MARKER) begin
      if (max_small) begin
        has_res  = 1'b1;
        res.kind = KIND_REJECT;
        res.why  = WHY_SIZE;
      end else if (byte_r != MARKER_BYTE) begin
        has_res  = 1'b1;
        res.kind = KIND_REJECT;
        res.why  = WHY_MARKER;
      end else begin
        header_pos_next = POS_TYPE;
        held_type_next  = '0;
        length_acc_next = '0;
      end
    end else if (header_pos == POS_TYPE) begin
      held_type_next  = byte_r;
      header_pos_next = header_pos + POS_W'(1);
    end else if (header_pos < POS_LAST) begin
      length_acc_next = acc_shift;
      header_pos_next = header_pos + POS_W'(1);
    end else begin
      // header complete: type check wins over size check
      length_acc_next = acc_shift;
      header_pos_next = POS_MARKER;
      res.ftype       = held_type;
      if (!type_ok) begin
        has_res  = 1'b1;
        res.kind = KIND_REJECT;
        res.why  = WHY_TYPE;
      end else if (max_small || acc_shift > limit) begin
        has_res  = 1'b1;
        res.kind = KIND_REJECT;
        res.why  = WHY_SIZE;
      end else if (acc_shift == '0) begin
        has_res  = 1'b1;
        res.kind = KIND_EMPTY;
        res.fend = 1'b1;
      end else begin
        bytes_left_next = acc_shift;
        in_payload_next = 1'b1;
      end
    end
  end

  // hold the byte only when its result has nowhere to go
  assign advance   = in_full && (!has_res || res_take);
  assign in_ready  = !in_full || advance;
  assign res_valid = advance && has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pos <= POS_MARKER;
      in_payload <= 1'b0;
      held_type  <= '0;
      length_acc <= '0;
      bytes_left <= '0;
    end else if (advance) begin
      header_pos <= header_pos_next;
      in_payload <= in_payload_next;
      held_type  <= held_type_next;
      length_acc <= length_acc_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

FILE: src/lpfd_out_reg.sv
module lpfd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lpfd_pkg::result_t    res,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lpfd_pkg::result_t    out_res
);
  import lpfd_pkg::*;

  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

FILE: sim/tb_length_prefixed_frame_deframer.sv
`timescale 1ns / 1ps
module tb_length_prefixed_frame_deframer;
  import lpfd_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lpfd_byte_if   byte_ch ();
  lpfd_result_if res_ch ();

  length_prefixed_frame_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (byte_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [BYTE_W-1:0] raw_stream_q[$];
  result_t           due_frame_out[$];
  int unsigned       bytes_queued;
  int unsigned       bytes_taken;
  int unsigned       err_cnt;
  bit                steady_run;
  bit                byte_took;

  // shadow of the block: register file and frame tracking state
  cfg_t              accept_cfg;
  logic [POS_W-1:0]  hdr_cnt;
  bit                payload_on;
  logic [BYTE_W-1:0] cur_type;
  logic [LEN_W-1:0]  len_shift;
  logic [LEN_W-1:0]  remain;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit type_ok(input logic [BYTE_W-1:0] t);
    return t == accept_cfg.plain_type_a || t == accept_cfg.plain_type_b ||
           t == accept_cfg.sealed_type;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_type();
    case ($urandom_range(2))
      0: return accept_cfg.plain_type_a;
      1: return accept_cfg.plain_type_b;
      default: return accept_cfg.sealed_type;
    endcase
  endfunction

  function automatic void deframe_step(input logic [BYTE_W-1:0] b);
    result_t r;
    bit      emit;
    r.kind  = KIND_DATA;
    r.data  = '0;
    r.ftype = '0;
    r.fend  = 1'b0;
    r.why   = WHY_NONE;
    emit    = 1'b0;
    if (payload_on) begin
      r.data  = b;
      r.ftype = cur_type;
      r.fend  = (remain <= 1);
      emit    = 1'b1;
      if (remain <= 1) begin
        remain     = '0;
        payload_on = 1'b0;
        hdr_cnt    = POS_MARKER;
      end else begin
        remain = remain - 1'b1;
      end
    end else if (hdr_cnt == POS_MARKER) begin
      if (accept_cfg.max_frame_size < HEADER_BYTES) begin
        r.kind = KIND_REJECT;
        r.why  = WHY_SIZE;
        emit   = 1'b1;
      end else if (b != MARKER_BYTE) begin
        r.kind = KIND_REJECT;
        r.why  = WHY_MARKER;
        emit   = 1'b1;
      end else begin
        hdr_cnt   = POS_TYPE;
        cur_type  = '0;
        len_shift = '0;
      end
    end else if (hdr_cnt == POS_TYPE) begin
      cur_type = b;
      hdr_cnt  = hdr_cnt + 1'b1;
    end else begin
      len_shift = {len_shift[LEN_W-BYTE_W-1:0], b};
      if (hdr_cnt != POS_LAST) begin
        hdr_cnt = hdr_cnt + 1'b1;
      end else begin
        // header complete: type check wins over the size check
        hdr_cnt = POS_MARKER;
        r.ftype = cur_type;
        if (!type_ok(cur_type)) begin
          r.kind = KIND_REJECT;
          r.why  = WHY_TYPE;
          emit   = 1'b1;
        end else if (accept_cfg.max_frame_size < HEADER_BYTES ||
                     len_shift > accept_cfg.max_frame_size - HEADER_BYTES) begin
          r.kind = KIND_REJECT;
          r.why  = WHY_SIZE;
          emit   = 1'b1;
        end else if (len_shift == 0) begin
          r.kind = KIND_EMPTY;
          r.fend = 1'b1;
          emit   = 1'b1;
        end else begin
          remain     = len_shift;
          payload_on = 1'b1;
        end
      end
    end
    if (emit) due_frame_out.push_back(r);
  endfunction

  function automatic void push_byte(input logic [BYTE_W-1:0] b);
    raw_stream_q.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void push_header(input logic [BYTE_W-1:0] t, input logic [LEN_W-1:0] len);
    push_byte(MARKER_BYTE);
    push_byte(t);
    push_byte(len[31:24]);
    push_byte(len[23:16]);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
  endfunction

  // mostly well-formed frames sized against the current limit, plus bad types,
  // oversized lengths and non-marker junk
  function automatic void add_random_frames(input int unsigned n);
    int unsigned       stop_at;
    int unsigned       roll;
    int unsigned       cap;
    logic [LEN_W-1:0]  lim;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] t;
    stop_at = bytes_queued + n;
    while (bytes_queued < stop_at) begin
      roll = $urandom_range(99);
      lim  = (accept_cfg.max_frame_size < HEADER_BYTES) ? '0 :
             accept_cfg.max_frame_size - HEADER_BYTES;
      if (roll < 70) begin
        cap = (roll < 6) ? 60 : 10;
        if (lim <= 40 && $urandom_range(3) == 0) len = lim;
        else len = $urandom_range((lim < cap) ? lim : cap);
        push_header(pick_type(), len);
        for (int unsigned i = 0; i < len; i++) push_byte($urandom_range(255));
      end else if (roll < 80) begin
        do t = $urandom_range(255); while (type_ok(t));
        push_header(t, $urandom());
      end else if (roll < 88) begin
        push_header(pick_type(), $urandom_range(32'hFFFF_FFFF, lim + 1));
      end else begin
        repeat ($urandom_range(3, 1)) begin
          do t = $urandom_range(255); while (t == MARKER_BYTE);
          push_byte(t);
        end
      end
    end
  endfunction

  // hold until every byte is taken and every result is back, then let the
  // pipeline settle in case header bytes are still in flight
  task automatic drain_all();
    while (raw_stream_q.size() != 0 || bytes_taken != bytes_queued ||
           due_frame_out.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
    logic [APB_DATA_W-1:0] want;
    logic [APB_DATA_W-1:0] got;
    want = '0;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MAX_FRAME: begin
        accept_cfg.max_frame_size = val;
        want = val;
      end
      REG_TYPE_A: begin
        accept_cfg.plain_type_a = val[BYTE_W-1:0];
        want = APB_DATA_W'(val[BYTE_W-1:0]);
      end
      REG_TYPE_B: begin
        accept_cfg.plain_type_b = val[BYTE_W-1:0];
        want = APB_DATA_W'(val[BYTE_W-1:0]);
      end
      REG_SEALED: begin
        accept_cfg.sealed_type = val[BYTE_W-1:0];
        want = APB_DATA_W'(val[BYTE_W-1:0]);
      end
    endcase
    // read it back
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $error("prdata %s: expected %0h, got %0h", idx.name(), want, got);
      err_cnt++;
    end
  endtask

  task automatic load_cfg(input logic [LEN_W-1:0] max_size, input logic [BYTE_W-1:0] ta,
                          input logic [BYTE_W-1:0] tb, input logic [BYTE_W-1:0] ts);
    set_reg(REG_MAX_FRAME, max_size);
    set_reg(REG_TYPE_A, APB_DATA_W'(ta));
    set_reg(REG_TYPE_B, APB_DATA_W'(tb));
    set_reg(REG_SEALED, APB_DATA_W'(ts));
  endtask

  always @(negedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_ch.valid || byte_took) begin
      if (raw_stream_q.size() != 0 && (steady_run || $urandom_range(99) >= 19)) begin
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= raw_stream_q.pop_front();
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
    byte_took = 1'b0;
  end

  always @(negedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= steady_run || ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      deframe_step(byte_ch.in_byte);
      bytes_taken++;
      byte_took = 1'b1;
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_frame_out.size() == 0) begin
        $error("out_kind: expected no transaction, got %0d", res_ch.out_kind);
        err_cnt++;
      end else begin
        want = due_frame_out.pop_front();
        if (res_ch.out_kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, res_ch.out_kind);
          err_cnt++;
        end
        if (res_ch.out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, res_ch.out_byte);
          err_cnt++;
        end
        if (res_ch.frame_kind !== want.ftype) begin
          $error("frame_kind: expected %0h, got %0h", want.ftype, res_ch.frame_kind);
          err_cnt++;
        end
        if (res_ch.frame_end !== want.fend) begin
          $error("frame_end: expected %0b, got %0b", want.fend, res_ch.frame_end);
          err_cnt++;
        end
        if (res_ch.reject_reason !== want.why) begin
          $error("reject_reason: expected %0d, got %0d", want.why, res_ch.reject_reason);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_length_prefixed_frame_deframer: errors");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    res_ch.ready    = 1'b0;
    steady_run      = 1'b0;
    byte_took       = 1'b0;
    err_cnt         = 0;
    bytes_queued    = 0;
    bytes_taken     = 0;
    accept_cfg      = '{RST_MAX_FRAME, RST_TYPE_A, RST_TYPE_B, RST_SEALED};
    hdr_cnt         = POS_MARKER;
    payload_on      = 1'b0;
    cur_type        = '0;
    len_shift       = '0;
    remain          = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // hunting bytes, one-byte and two-byte payloads, empty frame,
    // bad type with oversized length, length one past the limit
    push_byte(8'h00);
    push_byte(8'hFF);
    push_header(RST_TYPE_A, 32'd1);
    push_byte(8'hFF);
    push_header(RST_TYPE_B, 32'd0);
    push_header(8'hFF, 32'hFFFF_FFFF);
    push_header(RST_SEALED, 32'd65537);
    push_header(RST_SEALED, 32'd2);
    push_byte(8'h00);
    push_byte(MARKER_BYTE);
    add_random_frames(120);
    drain_all();

    // register writes under a running payload must not cut it short
    push_header(RST_TYPE_A, 32'd6);
    repeat (3) push_byte($urandom_range(255));
    drain_all();
    set_reg(REG_MAX_FRAME, 32'd5);
    set_reg(REG_TYPE_A, 32'h44);
    repeat (3) push_byte($urandom_range(255));
    push_byte(MARKER_BYTE);
    push_byte(8'h77);
    drain_all();

    // limit drops while the header is half taken in
    set_reg(REG_MAX_FRAME, RST_MAX_FRAME);
    push_byte(MARKER_BYTE);
    push_byte(RST_TYPE_B);
    push_byte(8'h00);
    push_byte(8'h00);
    drain_all();
    set_reg(REG_MAX_FRAME, 32'd5);
    push_byte(8'h00);
    push_byte(8'h00);
    drain_all();

    load_cfg(32'd16, 8'h10, 8'h20, 8'h30);
    add_random_frames(150);
    drain_all();
    load_cfg(32'hFFFF_FFFF, 8'hFF, 8'h80, 8'h7F);
    add_random_frames(150);
    drain_all();
    load_cfg(32'd6, 8'h00, 8'h00, 8'hFF);
    add_random_frames(100);
    drain_all();
    load_cfg(32'd5, 8'h01, 8'h02, 8'h03);
    add_random_frames(40);
    drain_all();
    load_cfg(32'd0, 8'hAA, 8'h55, 8'h01);
    add_random_frames(20);
    drain_all();

    load_cfg(RST_MAX_FRAME, RST_TYPE_A, RST_TYPE_B, RST_SEALED);
    steady_run = 1'b1;
    add_random_frames(250);
    drain_all();
    steady_run = 1'b0;

    load_cfg(32'd7, 8'h11, 8'h22, 8'h33);
    add_random_frames(100);
    drain_all();
    load_cfg(32'd300, 8'h00, 8'h02, 8'h01);
    add_random_frames(120);
    drain_all();
    repeat (10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb_length_prefixed_frame_deframer: clean");
    end else begin
      $display("tb_length_prefixed_frame_deframer: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/lpfd_pkg.sv
src/lpfd_ifs.sv
src/lpfd_cfg_regs.sv
src/lpfd_parser.sv
src/lpfd_out_reg.sv
src/length_prefixed_frame_deframer.sv
sim/tb_length_prefixed_frame_deframer.sv
